// File: sv/ccwl_pkg.sv
`timescale 1ns / 1ps

package ccwl_pkg;

   // Window length limit; positions from 32 up never match (entries are 32 bits)
   localparam int unsigned MAX_PATTERN_LENGTH = 32;

   localparam int unsigned REQ_W        = 2;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned CLASS_W      = 32;
   localparam int unsigned LEN_W        = 6;
   localparam int unsigned TABLE_ADDR_W = BYTE_W;
   localparam int unsigned TABLE_DEPTH  = 1 << TABLE_ADDR_W;

   localparam logic [LEN_W-1:0]  PATTERN_LENGTH_RESET = LEN_W'(32);
   localparam logic [BYTE_W-1:0] NEWLINE_BYTE         = 8'h0A;

   typedef enum logic [REQ_W-1:0] {
      REQ_LOAD   = 2'd0,
      REQ_TEXT   = 2'd1,
      REQ_EOL    = 2'd2,
      REQ_UNUSED = 2'd3
   } req_code_type;

   // Operation carried into the match stage
   typedef enum logic [1:0] {
      OP_NONE,
      OP_TEXT,
      OP_EOL
   } op_type;

   // Match stage status back to the front end
   typedef struct packed {
      logic ready;    // stage can take a new operation this cycle
   } stage_status_type;

endpackage

// File: sv/ccwl_class_mem.sv
`timescale 1ns / 1ps

// Class table: one write port, one registered read port.
module ccwl_class_mem (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [ccwl_pkg::TABLE_ADDR_W-1:0]   wr_addr,
   input  logic [ccwl_pkg::CLASS_W-1:0]        wr_data,
   input  logic                                rd_en,
   input  logic [ccwl_pkg::TABLE_ADDR_W-1:0]   rd_addr,
   output logic [ccwl_pkg::CLASS_W-1:0]        rd_data
);

   logic [ccwl_pkg::CLASS_W-1:0] mem [ccwl_pkg::TABLE_DEPTH];
   logic [ccwl_pkg::CLASS_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/ccwl_shift_and.sv
`timescale 1ns / 1ps

// Match stage: shift-and vector, sticky line flag and result register.
module ccwl_shift_and #(
   parameter int unsigned MAX_LEN = ccwl_pkg::MAX_PATTERN_LENGTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ccwl_pkg::op_type                  issue_op,
   input  logic [ccwl_pkg::CLASS_W-1:0]      class_data,
   input  logic [ccwl_pkg::LEN_W-1:0]        pattern_length,
   output ccwl_pkg::stage_status_type        status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_line_matched
);

   localparam int unsigned IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int unsigned WLEN_W = ccwl_pkg::LEN_W + 1;

   ccwl_pkg::op_type    op_ff, op_in;
   logic [MAX_LEN-1:0]  vec_ff, vec_in;
   logic                hit_ff, hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_match_ff, rsp_match_in;

   logic [MAX_LEN-1:0]  class_ext;
   logic [MAX_LEN-1:0]  vec_next;
   logic [WLEN_W-1:0]   win_len;
   logic [IDX_W-1:0]    win_idx;
   logic                win_hit;
   logic                advance;

   // Table entry widened or trimmed to the vector; high positions accept nothing
   always_comb begin
      for (int i = 0; i < MAX_LEN; i++) begin
         class_ext[i] = (i < ccwl_pkg::CLASS_W) ? class_data[i % ccwl_pkg::CLASS_W] : 1'b0;
      end
   end

   always_comb begin
      if ({1'b0, pattern_length} > WLEN_W'(MAX_LEN)) begin
         win_len = WLEN_W'(MAX_LEN);
      end else begin
         win_len = {1'b0, pattern_length};
      end
      win_idx  = IDX_W'(win_len - WLEN_W'(1));
      vec_next = MAX_LEN'({vec_ff, 1'b1}) & class_ext;
      win_hit  = (win_len != '0) && vec_next[win_idx];
   end

   // A held end of line waits only for the result register
   assign advance = (op_ff != ccwl_pkg::OP_EOL) || !rsp_valid_ff || rsp_ready;

   always_comb begin
      op_in        = advance ? issue_op : op_ff;
      vec_in       = vec_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_match_in = rsp_match_ff;
      unique case (op_ff)
         ccwl_pkg::OP_TEXT: begin
            vec_in = vec_next;
            hit_in = hit_ff | win_hit;
         end
         ccwl_pkg::OP_EOL: begin
            if (advance) begin
               vec_in       = '0;
               hit_in       = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_match_in = hit_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= ccwl_pkg::OP_NONE;
         vec_ff       <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         op_ff        <= op_in;
         vec_ff       <= vec_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_match_ff <= rsp_match_in;
   end

   assign status.ready     = advance;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_matched = rsp_match_ff;

endmodule

// File: sv/char_class_window_line_matcher.sv
`timescale 1ns / 1ps

// Channel   Ports                                            Direction
// -------   ----------------------------------------------   ---------
// req       req_valid/req_ready, req_type, req_byte_value,     in
//           req_class_mask
// rsp       rsp_valid/rsp_ready, rsp_line_matched              out
// csr       csr_wr_en, csr_wr_data (pattern_length)            in
//
// One item per cycle sustained. An item is decoded and, for text, the class
// table memory is read at the accept edge; the next cycle updates the
// shift-and vector from the registered read data. An end of line passes from the
// op register to the result register. Synchronous active-high reset clears the
// vector, the line flag and the pipeline; the table is undefined until loaded.
// req_ready drops only while an end of line waits behind an unread result.
module char_class_window_line_matcher #(
   parameter int unsigned MAX_PATTERN_LENGTH = ccwl_pkg::MAX_PATTERN_LENGTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // item input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ccwl_pkg::REQ_W-1:0]          req_type,
   input  logic [ccwl_pkg::BYTE_W-1:0]         req_byte_value,
   input  logic [ccwl_pkg::CLASS_W-1:0]        req_class_mask,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_line_matched,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [ccwl_pkg::LEN_W-1:0]          csr_wr_data
);

   logic [ccwl_pkg::LEN_W-1:0]   pattern_length_ff, pattern_length_in;
   ccwl_pkg::req_code_type       req_code;
   ccwl_pkg::op_type             dec_op, issue_op;
   ccwl_pkg::stage_status_type   stage_status;
   logic                         accept;
   logic                         tbl_wr_en;
   logic                         tbl_rd_en;
   logic [ccwl_pkg::CLASS_W-1:0] tbl_rd_data;

   // pattern length register
   assign pattern_length_in = csr_wr_en ? csr_wr_data : pattern_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= ccwl_pkg::PATTERN_LENGTH_RESET;
      end else begin
         pattern_length_ff <= pattern_length_in;
      end
   end

   assign req_ready = stage_status.ready;
   assign accept    = req_valid && req_ready;
   assign req_code  = ccwl_pkg::req_code_type'(req_type);

   // decode: a newline text byte behaves as end of line; code 3 is dropped
   always_comb begin
      dec_op    = ccwl_pkg::OP_NONE;
      tbl_wr_en = 1'b0;
      tbl_rd_en = 1'b0;
      unique case (req_code)
         ccwl_pkg::REQ_LOAD: begin
            tbl_wr_en = accept;
         end
         ccwl_pkg::REQ_TEXT: begin
            if (req_byte_value == ccwl_pkg::NEWLINE_BYTE) begin
               dec_op = ccwl_pkg::OP_EOL;
            end else begin
               dec_op    = ccwl_pkg::OP_TEXT;
               tbl_rd_en = accept;
            end
         end
         ccwl_pkg::REQ_EOL: begin
            dec_op = ccwl_pkg::OP_EOL;
         end
         default: begin
         end
      endcase
      issue_op = accept ? dec_op : ccwl_pkg::OP_NONE;
   end

   // A load written at one edge is seen by a text read at any later edge,
   // and a text item read before a load keeps the old entry: no forwarding.
   ccwl_class_mem u_class_mem (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (req_byte_value),
      .wr_data (req_class_mask),
      .rd_en   (tbl_rd_en),
      .rd_addr (req_byte_value),
      .rd_data (tbl_rd_data)
   );

   ccwl_shift_and #(
      .MAX_LEN (MAX_PATTERN_LENGTH)
   ) u_shift_and (
      .clock            (clock),
      .reset            (reset),
      .issue_op         (issue_op),
      .class_data       (tbl_rd_data),
      .pattern_length   (pattern_length_ff),
      .status           (stage_status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_matched (rsp_line_matched)
   );

endmodule
